// ===== rtl/ldtc_pkg.sv =====
// Shared constants and types for the log-domain timing curve block.
package ldtc_pkg;

    // Fixed-point format of every value on the ports
    localparam int FRAC_BITS = 16;
    // ln(2) scaled by 2^28, rounded
    localparam logic [27:0] LN2_Q28 = 28'd186065280;
    // Width of the ln result: sign plus integer part plus fraction
    localparam int LN_W = FRAC_BITS + 6;
    // Number of log2 fraction bits produced by the squaring chain
    localparam int L2_FRAC = 30;

    // Configuration register indexes
    localparam logic [2:0] REG_BIAS    = 3'd0;
    localparam logic [2:0] REG_FLOOR   = 3'd1;
    localparam logic [2:0] REG_CENTER  = 3'd2;
    localparam logic [2:0] REG_HALF    = 3'd3;
    localparam logic [2:0] REG_SLOPE   = 3'd4;
    localparam logic [2:0] REG_CEILING = 3'd5;

    // Side information that rides through the divider with each beat
    typedef struct packed {
        logic        non_pos;   // sample plus bias was not positive
        logic        on_left;   // falling line region
        logic        in_join;   // smooth join region
        logic [32:0] neg_x;     // -x, used on the falling line
    } t_div_tag;

endpackage

// ===== rtl/ldtc_log2.sv =====
// Pipelined natural logarithm: normalize, 30 squaring stages, scale by ln(2).
module ldtc_log2 import ldtc_pkg::*; #(
    parameter int TAG_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [32:0]            i_sum,
    input  logic [TAG_W-1:0]       i_tag,
    output logic                   o_vld,
    output logic signed [LN_W-1:0] o_ln,
    output logic [TAG_W-1:0]       o_tag
);

    localparam int NS = L2_FRAC + 1;   // normalize stage plus squaring stages

    logic [NS-1:0]      r_vld;
    logic [30:0]        r_mant [NS];
    logic [L2_FRAC-1:0] r_frac [NS];
    logic [5:0]         r_exp  [NS];
    logic [TAG_W-1:0]   r_tag  [NS];

    logic [5:0]  n_exp;
    logic [64:0] n_shift;

    // Find the leading one and place it at bit 30 (truncating)
    always_comb begin
        n_exp = '0;
        for (int i = 0; i < 33; i++) begin
            if (i_sum[i]) n_exp = 6'(i);
        end
        n_shift = {i_sum, 32'b0} >> (n_exp + 6'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mant[0] <= n_shift[30:0];
            r_frac[0] <= '0;
            r_exp[0]  <= n_exp;
            r_tag[0]  <= i_tag;
        end
    end

    // Square the mantissa once per stage; a carry past 2.0 yields a fraction bit
    for (genvar k = 1; k < NS; k++) begin : g_sq
        logic [61:0] n_sq;
        logic [31:0] n_top;
        assign n_sq  = r_mant[k-1] * r_mant[k-1];
        assign n_top = n_sq[61:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mant[k] <= n_top[31] ? n_top[31:1] : n_top[30:0];
                r_frac[k] <= r_frac[k-1] | (n_top[31] ? (L2_FRAC'(1) << (L2_FRAC - k))
                                                      : '0);
                r_exp[k]  <= r_exp[k-1];
                r_tag[k]  <= r_tag[k-1];
            end
        end
    end

    // Scale integer and fraction parts of log2 by ln(2)
    logic               r_va, r_vb;
    logic signed [35:0] r_p1;
    logic [57:0]        r_p2;
    logic [TAG_W-1:0]   r_ta, r_tb;
    logic signed [LN_W-1:0] r_ln;

    logic signed [6:0]  n_eoff;
    logic signed [35:0] n_p1;
    logic signed [63:0] n_prod;

    assign n_eoff = $signed({1'b0, r_exp[NS-1]}) - 7'(FRAC_BITS);
    assign n_p1   = 36'(n_eoff * $signed({1'b0, LN2_Q28}));
    assign n_prod = ({{28{r_p1[35]}}, r_p1} <<< L2_FRAC)
                  + $signed({6'b0, r_p2})
                  + (64'sd1 <<< (57 - FRAC_BITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= r_vld[NS-1];
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= n_p1;
            r_p2 <= r_frac[NS-1] * LN2_Q28;
            r_ta <= r_tag[NS-1];
            r_ln <= n_prod[63:58-FRAC_BITS];
            r_tb <= r_ta;
        end
    end

    assign o_vld = r_vb;
    assign o_ln  = r_ln;
    assign o_tag = r_tb;

endmodule

// ===== rtl/ldtc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, 32-bit quotient.
module ldtc_div import ldtc_pkg::*; #(
    parameter int TAG_W = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [65:0]      i_num,
    input  logic [33:0]      i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [31:0]      o_quo,
    output logic [TAG_W-1:0] o_tag
);

    localparam int QB = 32;

    logic [QB:0]      r_vld;
    logic [33:0]      r_rem [QB+1];
    logic [QB-1:0]    r_lo  [QB+1];
    logic [QB-1:0]    r_quo [QB+1];
    logic [TAG_W-1:0] r_tag [QB+1];

    // Load the upper half as the running remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[65:32];
            r_lo[0]  <= i_num[31:0];
            r_quo[0] <= '0;
            r_tag[0] <= i_tag;
        end
    end

    // Shift in one dividend bit, subtract when the divisor fits
    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [34:0] n_sh;
        logic        n_ge;
        logic [34:0] n_diff;
        assign n_sh   = {r_rem[k-1], r_lo[k-1][QB-1]};
        assign n_ge   = n_sh >= {1'b0, i_den};
        assign n_diff = n_sh - {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? n_diff[33:0] : n_sh[33:0];
                r_lo[k]  <= {r_lo[k-1][QB-2:0], 1'b0};
                r_quo[k] <= {r_quo[k-1][QB-2:0], n_ge};
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_vld = r_vld[QB];
    assign o_quo = r_quo[QB];
    assign o_tag = r_tag[QB];

endmodule

// ===== rtl/log_domain_timing_curve.sv =====
// Top level of the log-domain timing curve: registers, curve stages, output skid.
//
// Each amplitude sample yields one time constant. Samples may enter on every
// clock, so one sample per cycle is sustained while the skid entry is empty.
// The depth is set by the 30-stage squaring chain of the logarithm and the
// 33-stage divider of the join term. One skid entry sits behind the output
// register. When the result consumer stalls, the next result still moves into
// the skid entry. The pipeline then holds until the consumer takes the waiting
// result. Write the configuration registers only while no sample is in flight;
// the configuration port is always ready.
module log_domain_timing_curve import ldtc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_amplitude,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_time_constant,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Configuration registers
    logic [31:0] r_bias, r_tau_floor, r_center, r_half, r_slope, r_tau_ceiling;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias        <= '0;
            r_tau_floor   <= 32'(1) << FRAC_BITS;
            r_center      <= '0;
            r_half        <= 32'(1) << FRAC_BITS;
            r_slope       <= 32'(1) << FRAC_BITS;
            r_tau_ceiling <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BIAS:    r_bias        <= i_cfg_data;
                REG_FLOOR:   r_tau_floor   <= i_cfg_data;
                REG_CENTER:  r_center      <= i_cfg_data;
                REG_HALF:    r_half        <= i_cfg_data;
                REG_SLOPE:   r_slope       <= i_cfg_data;
                REG_CEILING: r_tau_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances while the skid slot is empty
    logic r_sv;
    logic w_en;
    assign w_en    = !r_sv;
    assign o_ready = w_en;

    // Stage 0: add bias, flag non-positive sums
    logic        r0_v, r0_np;
    logic [32:0] r0_sum;
    logic signed [33:0] n0_sum;
    assign n0_sum = $signed({{2{i_amplitude[31]}}, i_amplitude}) + $signed({2'b0, r_bias});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_v <= 1'b0;
        else if (w_en) r0_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_sum <= n0_sum[32:0];
            r0_np  <= n0_sum[33] || (n0_sum == '0);
        end
    end

    // Logarithm
    logic                   w_lv, w_lnp;
    logic signed [LN_W-1:0] w_ln;

    ldtc_log2 #(.TAG_W(1)) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r0_v),
        .i_sum   (r0_sum),
        .i_tag   (r0_np),
        .o_vld   (w_lv),
        .o_ln    (w_ln),
        .o_tag   (w_lnp)
    );

    // Stage 1: subtract the join center
    logic               r1_v, r1_np;
    logic signed [33:0] r1_x;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_en) r1_v <= w_lv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x  <= 34'(w_ln) - {{2{r_center[31]}}, r_center};
            r1_np <= w_lnp;
        end
    end

    // Stage 2: pick the curve region, form -x and h - x
    logic signed [33:0] n2_h;
    logic signed [33:0] n2_nx, n2_d;
    assign n2_h  = $signed({2'b0, r_half});
    assign n2_nx = -r1_x;
    assign n2_d  = n2_h - r1_x;

    logic        r2_v;
    t_div_tag    r2_tag;
    logic [32:0] r2_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_tag.non_pos <= r1_np;
            r2_tag.on_left <= r1_x <= -n2_h;
            r2_tag.in_join <= !(r1_x <= -n2_h) && (r1_x < n2_h);
            r2_tag.neg_x   <= n2_nx[32:0];
            r2_d           <= n2_d[32:0];
        end
    end

    // Stage 3: partial products of (h - x) squared
    logic        r3_v;
    t_div_tag    r3_tag;
    logic [33:0] r3_hh;
    logic [32:0] r3_hl;
    logic [31:0] r3_ll;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_en) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_hh  <= r2_d[32:16] * r2_d[32:16];
            r3_hl  <= r2_d[32:16] * r2_d[15:0];
            r3_ll  <= r2_d[15:0] * r2_d[15:0];
            r3_tag <= r2_tag;
        end
    end

    // Stage 4: sum the partial products
    logic        r4_v;
    t_div_tag    r4_tag;
    logic [65:0] r4_sq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_en) r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sq  <= ({r3_hh, 32'b0}) + (66'(r3_hl) << 17) + 66'(r3_ll);
            r4_tag <= r3_tag;
        end
    end

    // Divide by 4h
    logic        w_dv;
    logic [31:0] w_q;
    t_div_tag    w_dtag;

    ldtc_div #(.TAG_W($bits(t_div_tag))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r4_v),
        .i_num   (r4_sq),
        .i_den   ({r_half, 2'b00}),
        .i_tag   (r4_tag),
        .o_vld   (w_dv),
        .o_quo   (w_q),
        .o_tag   (w_dtag)
    );

    // Stage 5: slope times the selected operand, in two halves
    logic [32:0] n5_m;
    always_comb begin
        priority if (w_dtag.on_left) n5_m = w_dtag.neg_x;
        else if (w_dtag.in_join)     n5_m = {1'b0, w_q};
        else                         n5_m = '0;
    end

    logic        r5_v, r5_np;
    logic [48:0] r5_pa;
    logic [47:0] r5_pb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (w_en) r5_v <= w_dv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_pa <= r_slope * n5_m[32:16];
            r5_pb <= r_slope * n5_m[15:0];
            r5_np <= w_dtag.non_pos;
        end
    end

    // Stage 6: drop the fraction bits and add the floor
    logic [64:0] n6_prod;
    logic        r6_v, r6_np;
    logic [49:0] r6_tau;
    assign n6_prod = {r5_pa, 16'b0} + 65'(r5_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (w_en) r6_v <= r5_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_tau <= 50'(n6_prod[64:FRAC_BITS]) + 50'(r_tau_floor);
            r6_np  <= r5_np;
        end
    end

    // Clamp to the ceiling; a non-positive sum yields the ceiling
    logic [31:0] w_res;
    logic        w_push;
    assign w_push = w_en && r6_v;
    assign w_res  = (r6_np || (r6_tau > 50'(r_tau_ceiling))) ? r_tau_ceiling : r6_tau[31:0];

    // Output register with one skid slot
    logic        r_ov;
    logic [31:0] r_od, r_sd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_ready) begin
            r_ov <= r_sv || w_push;
            r_sv <= 1'b0;
        end else if (w_push) begin
            r_sv <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!r_ov || i_ready) begin
            r_od <= r_sv ? r_sd : w_res;
        end else if (w_push) begin
            r_sd <= w_res;
        end
    end

    assign o_valid         = r_ov;
    assign o_time_constant = r_od;

    // The skid slot only holds a beat behind a waiting result
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid slot full while output empty");

    // The skid slot fills only when the result was stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !i_ready))
        else $error("skid slot filled without output stall");

    // Results never exceed the ceiling
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_od <= r_tau_ceiling))
        else $error("time constant above ceiling");

endmodule

// ===== dv/tb_log_domain_timing_curve.sv =====
// Testbench for the log-domain timing curve: random and directed samples checked against a predictor.
`timescale 1ns / 1ps

module tb_log_domain_timing_curve;
    import ldtc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_amplitude;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_time_constant;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // Shadow copies of the configuration registers
    logic [31:0] bias_r    = 32'd0;
    logic [31:0] floor_r   = 32'h0001_0000;
    logic [31:0] center_r  = 32'd0;
    logic [31:0] half_r    = 32'h0001_0000;
    logic [31:0] slope_r   = 32'h0001_0000;
    logic [31:0] ceiling_r = 32'hFFFF_FFFF;

    logic [31:0] sample_q[$];
    logic [31:0] tau_q[$];
    logic        hold_send;
    logic        quiet;
    int          errors;
    int          n_samples;
    int          n_results;
    int          n_writes;
    int          cycles;

    log_domain_timing_curve dut (.*);

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // floor(a*b/c), saturating at all ones
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b,
                                                   logic [63:0] c);
        logic [127:0] quo;
        quo = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
        if (quo[127:64] != 0)
            return '1;
        return quo[63:0];
    endfunction

    // Time constant for one sample under the current register settings
    function automatic logic [31:0] curve_tau(logic [31:0] amp);
        longint      total, lnv, x, h, l2, prod;
        logic [63:0] mant, frac, term, tau, d, q;
        int          e;
        total = longint'($signed(amp)) + longint'({32'd0, bias_r});
        if (total <= 0)
            return ceiling_r;
        // log2 by repeated squaring of a Q2.30 mantissa
        e = 63;
        while (e > 0 && total[e] == 1'b0)
            e--;
        mant = (e >= 30) ? (total >> (e - 30)) : (total << (30 - e));
        frac = 0;
        for (int i = 1; i <= 30; i++) begin
            mant = (mant * mant) >> 30;
            if (mant >= (64'd2 << 30)) begin
                mant = mant >> 1;
                frac[30 - i] = 1'b1;
            end
        end
        l2   = longint'(e - FRAC_BITS) * (longint'(1) << 30) + longint'(frac);
        prod = l2 * longint'({36'd0, LN2_Q28}) + (longint'(1) << (57 - FRAC_BITS));
        lnv  = prod >>> (58 - FRAC_BITS);
        x = lnv - longint'($signed(center_r));
        h = longint'({32'd0, half_r});
        term = 0;
        if (x <= -h) begin
            term = scaled_product(slope_r, -x, 64'd1 << FRAC_BITS);
        end else if (x < h) begin
            d    = h - x;
            q    = scaled_product(d, d, 64'd4 * h);
            term = scaled_product(slope_r, q, 64'd1 << FRAC_BITS);
        end
        tau = (term > ~{32'd0, floor_r}) ? '1 : term + floor_r;
        if (tau > {32'd0, ceiling_r})
            tau = ceiling_r;
        return tau[31:0];
    endfunction

    // Sample driver: count the beat that went, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_amplitude <= '0;
        end else begin
            if (i_valid && o_ready) begin
                tau_q.push_back(curve_tau(i_amplitude));
                n_samples++;
            end
            if (!i_valid || o_ready) begin
                if (sample_q.size() > 0 && !hold_send
                    && (quiet || $urandom_range(99) >= 16)) begin
                    i_valid     <= 1'b1;
                    i_amplitude <= sample_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_results++;
                if (tau_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected time_constant beat: expected none, actual %h",
                             $time, o_time_constant);
                end else begin
                    if (o_time_constant !== tau_q[0]) begin
                        errors++;
                        $display("%0t: time_constant mismatch: expected %h, actual %h",
                                 $time, tau_q[0], o_time_constant);
                    end
                    void'(tau_q.pop_front());
                end
            end
            i_ready <= quiet || ($urandom_range(99) >= 16);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_log_domain_timing_curve failed");
            $finish;
        end
    end

    // Write one register while the block is idle; mirror it in the shadow copy
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_writes++;
        case (idx)
            REG_BIAS:    bias_r    = val;
            REG_FLOOR:   floor_r   = val;
            REG_CENTER:  center_r  = val;
            REG_HALF:    half_r    = val;
            REG_SLOPE:   slope_r   = val;
            REG_CEILING: ceiling_r = val;
            default: ;
        endcase
    endtask

    // Wait until every queued sample went in and every result came back
    task automatic drain();
        while (sample_q.size() > 0 || i_valid || tau_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Random amplitude: mostly magnitudes spread over the log range
    function automatic logic [31:0] rand_amp();
        logic [31:0] v;
        int          k;
        case ($urandom_range(9))
            0: v = $urandom;
            1: v = $urandom_range(3) - 1;
            2: v = 32'h8000_0000 + $urandom_range(15);
            default: begin
                k = $urandom_range(31, 1);
                v = $urandom_range((32'd1 << k) - 1, 1);
                if ($urandom_range(7) == 0)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic rand_items(int n);
        repeat (n) sample_q.push_back(rand_amp());
    endtask

    task automatic rand_regs();
        write_reg(REG_BIAS,    $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h4_0000));
        write_reg(REG_FLOOR,   $urandom_range(32'h10_0000));
        write_reg(REG_CENTER,  $urandom_range(32'h18_0000) - 32'h0C_0000);
        write_reg(REG_HALF,    $urandom_range(32'h4_0000));
        write_reg(REG_SLOPE,   $urandom_range(32'h8_0000));
        write_reg(REG_CEILING, $urandom_range(1) ? 32'hFFFF_FFFF : $urandom);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        hold_send   = 1'b0;
        quiet       = 1'b0;
        n_writes    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings: extremes, zero, join region, left and flat sides
        sample_q = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1,
                     32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h0000_5E2D,
                     32'h0002_B7E1, 32'h0000_0100, 32'h0100_0000, 32'h0000_FFFF};
        drain();

        // Bias pushes negative samples positive; a sum of exactly zero
        write_reg(REG_BIAS, 32'h0001_0000);
        sample_q = '{32'hFFFF_0000, 32'hFFFF_0001, 32'hFFFE_FFFF, 32'h8000_0000};
        drain();

        // Zero half width, negative center, low ceiling that clamps; writes to unused indexes
        write_reg(REG_HALF, 32'd0);
        write_reg(REG_CENTER, 32'hFFFE_0000);
        write_reg(REG_CEILING, 32'h0003_0000);
        write_reg(REG_SLOPE, 32'h0004_0000);
        write_reg(REG_FLOOR, 32'h0000_8000);
        write_reg(3'd6, 32'hDEAD_BEEF);
        write_reg(3'd7, 32'h1234_5678);
        sample_q = '{32'h0000_22A5, 32'h0000_22A6, 32'h0, 32'h0000_0001, 32'h7FFF_FFFF};
        rand_items(20);
        drain();

        // All ones: maximum bias, floor, slope, half width; ceiling zero then max
        write_reg(REG_BIAS, 32'hFFFF_FFFF);
        write_reg(REG_FLOOR, 32'hFFFF_FFFF);
        write_reg(REG_CENTER, 32'h7FFF_FFFF);
        write_reg(REG_HALF, 32'hFFFF_FFFF);
        write_reg(REG_SLOPE, 32'hFFFF_FFFF);
        write_reg(REG_CEILING, 32'd0);
        sample_q = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
        drain();
        write_reg(REG_CEILING, 32'hFFFF_FFFF);
        write_reg(REG_CENTER, 32'h8000_0000);
        rand_items(10);
        drain();

        // Zero bias, floor, center and slope
        write_reg(REG_BIAS, 32'd0);
        write_reg(REG_FLOOR, 32'd0);
        write_reg(REG_CENTER, 32'd0);
        write_reg(REG_SLOPE, 32'd0);
        rand_items(10);
        drain();

        // Random settings; each phase pauses the sender midway, and one phase has no idling
        for (int p = 0; p < 8; p++) begin
            rand_regs();
            quiet = (p == 3);
            rand_items(22);
            while (sample_q.size() > 0)
                @(posedge i_clk);
            hold_send = 1'b1;
            while (i_valid || tau_q.size() > 0)
                @(posedge i_clk);
            hold_send = 1'b0;
            rand_items(22);
            drain();
        end
        quiet = 1'b0;

        drain();
        $display("Covered %0d samples, %0d results, %0d register writes over 14 settings",
                 n_samples, n_results, n_writes);
        $display("including extreme, zero-width and clamping settings, with random stalls");
        if (errors == 0) begin
            $display("tb_log_domain_timing_curve passed");
        end else begin
            $display("tb_log_domain_timing_curve failed");
        end
        $finish;
    end

endmodule
